FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/colex_pkg.sv
`default_nettype none

package colex_pkg;

  localparam int POSITIONS = 30;
  localparam int SET_BITS  = 8;
  localparam int RANK_W    = 23;
  localparam int MASK_W    = POSITIONS;
  localparam int K_W       = $clog2(SET_BITS + 1);
  localparam int POS_W     = $clog2(POSITIONS + 1);

  typedef logic [RANK_W-1:0] rank_t;
  typedef rank_t [SET_BITS:0] binom_row_t;
  typedef binom_row_t [POSITIONS:0] binom_tab_t;

  // What travels from one cell to the next.
  typedef struct packed {
    logic             valid;
    logic             oor;
    logic [K_W-1:0]   k;
    rank_t            rank;
    logic [MASK_W-1:0] mask;
  } stage_t;

  // Pascal's triangle, evaluated at elaboration. C(n,k) is 0 for n < k.
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n <= POSITIONS; n++) begin
      t[n][0] = rank_t'(1);
      for (int k = 1; k <= SET_BITS; k++) begin
        if (n > 0) begin
          t[n][k] = t[n-1][k-1] + t[n-1][k];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM      = build_binom();
  localparam rank_t      RANK_LIMIT = BINOM[POSITIONS][SET_BITS];

endpackage

`default_nettype wire

FILE: hw/rtl/colex_cell.sv
`default_nettype none

`include "assert_macros.svh"

module colex_cell import colex_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic [POS_W-1:0] pos,
  input  wire stage_t          upstream,
  output stage_t               downstream
);

  stage_t stage;
  rank_t  coef;
  logic   take;

  assign coef = BINOM[pos][upstream.k];
  // Scanning positions downward, the first one whose binomial fits is the pick for this k.
  assign take = (upstream.k != '0) && (coef <= upstream.rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= upstream.valid;
    end
    if (en) begin
      stage.oor <= upstream.oor;
      if (take) begin
        stage.k    <= upstream.k - K_W'(1);
        stage.rank <= upstream.rank - coef;
        stage.mask <= upstream.mask | (MASK_W'(1) << pos);
      end else begin
        stage.k    <= upstream.k;
        stage.rank <= upstream.rank;
        stage.mask <= upstream.mask;
      end
    end
  end

  assign downstream = stage;

  `ASSERT_IMPL(cell_count_a, clk, rst, downstream.valid && !downstream.oor,
    ($countones(downstream.mask) + int'(downstream.k)) == SET_BITS, "set bits plus k lost")
  `ASSERT_NEXT(cell_hold_a, clk, rst, !en, $stable(downstream), "cell moved while held")
  `ASSERT_NEXT(cell_rank_a, clk, rst, en && upstream.valid,
    downstream.rank <= $past(upstream.rank), "remaining rank grew")

endmodule

`default_nettype wire

FILE: hw/rtl/colex_combination_unrank.sv
`default_nettype none

// Colex unranking of 8-of-30 combinations. Each accepted rank comes back as a
// 30-bit mask with eight bits set, or as mask 0 with out_of_range high when the
// rank is C(30,8) = 5852925 or more. A rank passes an entry register and then a
// row of 30 cells, one per position from 29 down to 0; each cell compares the
// remaining rank with one constant binomial and, if it fits, sets its bit and
// subtracts. A new rank is taken every cycle while in_stall is low. The row
// advances as one: while a result waits under out_stall the whole row holds
// and in_stall is high.

`include "assert_macros.svh"

module colex_combination_unrank import colex_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [RANK_W-1:0] rank,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [MASK_W-1:0]      mask,
  output logic                   out_of_range
);

  stage_t entry;
  stage_t chain [POSITIONS+1];
  stage_t tail;
  logic   en;
  logic   too_big;

  assign tail      = chain[POSITIONS];
  assign out_valid = tail.valid;
  assign en        = !tail.valid || !out_stall;
  assign in_stall  = !en;
  assign too_big   = (rank >= RANK_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (en) begin
      entry.valid <= in_valid;
    end
    if (en) begin
      entry.oor  <= too_big;
      // An out-of-range beat starts with nothing left to pick, so it leaves with mask 0.
      entry.k    <= too_big ? '0 : K_W'(SET_BITS);
      entry.rank <= rank;
      entry.mask <= '0;
    end
  end

  assign chain[0] = entry;

  for (genvar i = 0; i < POSITIONS; i++) begin : g_cell
    colex_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .pos        (POS_W'(POSITIONS - 1 - i)),
      .upstream   (chain[i]),
      .downstream (chain[i+1])
    );
  end

  assign mask         = tail.mask;
  assign out_of_range = tail.oor;

  `ASSERT_IMPL(done_a, clk, rst, out_valid && !tail.oor,
    (tail.k == '0) && (tail.rank == '0), "rank not fully spent")
  `ASSERT_IMPL(popcount_a, clk, rst, out_valid && !tail.oor,
    $countones(tail.mask) == SET_BITS, "wrong number of set bits")
  `ASSERT_IMPL(err_mask_a, clk, rst, out_valid && tail.oor,
    tail.mask == '0, "mask not zero on error")

endmodule

`default_nettype wire
